/* rtl/signed_decimal_digit_emitter_macros.svh */
// Assertion helpers for the RTL files; sdde_emit.sv includes them.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SIGNED_DECIMAL_DIGIT_EMITTER_MACROS_SVH
`define SIGNED_DECIMAL_DIGIT_EMITTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDDE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sdde_pkg.sv */
package sdde_pkg;

    localparam int VALUE_W    = 16;
    localparam int MAG_W      = VALUE_W + 1;
    localparam int BCD_DIGITS = 5;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int POS_W      = 3;
    localparam int CNT_W      = $clog2(MAG_W + 1);

    localparam logic [DIGIT_W-1:0] MINUS_CODE  = 4'd10;
    localparam logic [DIGIT_W-1:0] DABBLE_LIM  = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD  = 4'd3;
    localparam logic [POS_W-1:0]   FIRST_POS   = 3'd1;

    typedef logic [BCD_W-1:0] bcd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } conv_status_t;

endpackage

/* rtl/sdde_value_if.sv */
interface sdde_value_if;
    logic                          valid;
    logic                          ready;
    logic signed [sdde_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* rtl/sdde_digit_if.sv */
interface sdde_digit_if;
    logic                          valid;
    logic                          ready;
    logic [sdde_pkg::POS_W-1:0]    digit_position;
    logic [sdde_pkg::DIGIT_W-1:0]  digit_code;
    logic                          last;

    modport source (output valid, output digit_position, output digit_code, output last,
                    input ready);
    modport sink   (input valid, input digit_position, input digit_code, input last,
                    output ready);
endinterface

/* rtl/sdde_dabble.sv */
module sdde_dabble (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [sdde_pkg::VALUE_W-1:0] value,
    output sdde_pkg::conv_status_t              status,
    output sdde_pkg::bcd_t                      bcd,
    output logic                                neg
);

    logic [sdde_pkg::MAG_W-1:0] bin_reg, bin_next;
    sdde_pkg::bcd_t             bcd_reg, bcd_next, adj;
    logic [sdde_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic                       neg_reg, neg_next;
    logic [sdde_pkg::MAG_W-1:0] mag;

    // Magnitude in 17 bits so that the most negative value stays exact.
    always_comb
    begin
        if (value[sdde_pkg::VALUE_W-1])
            mag = {1'b0, ~value} + sdde_pkg::MAG_W'(1);
        else
            mag = {1'b0, value};
    end

    // Add three to every BCD digit of five or more before the next shift.
    always_comb
    begin
        for (int i = 0; i < sdde_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*sdde_pkg::DIGIT_W +: sdde_pkg::DIGIT_W] >= sdde_pkg::DABBLE_LIM)
                adj[i*sdde_pkg::DIGIT_W +: sdde_pkg::DIGIT_W] =
                    bcd_reg[i*sdde_pkg::DIGIT_W +: sdde_pkg::DIGIT_W] + sdde_pkg::DABBLE_ADD;
            else
                adj[i*sdde_pkg::DIGIT_W +: sdde_pkg::DIGIT_W] =
                    bcd_reg[i*sdde_pkg::DIGIT_W +: sdde_pkg::DIGIT_W];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        if (start)
        begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = sdde_pkg::CNT_W'(sdde_pkg::MAG_W);
            busy_next = 1'b1;
            neg_next  = value[sdde_pkg::VALUE_W-1];
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[sdde_pkg::BCD_W-2:0], bin_reg[sdde_pkg::MAG_W-1]};
            bin_next = {bin_reg[sdde_pkg::MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg - sdde_pkg::CNT_W'(1);
            if (cnt_reg == sdde_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign bcd         = bcd_reg;
    assign neg         = neg_reg;

endmodule

/* rtl/sdde_emit.sv */
`include "signed_decimal_digit_emitter_macros.svh"

module sdde_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  sdde_pkg::bcd_t  bcd,
    input  logic            neg,
    output logic            idle,
    sdde_digit_if.source    digit_ch
);

    sdde_pkg::bcd_t               rem_reg, rem_next;
    logic [sdde_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                         neg_reg, neg_next;
    logic                         active_reg, active_next;
    logic                         minus_reg, minus_next;
    logic                         out_valid_reg, out_valid_next;
    logic [sdde_pkg::POS_W-1:0]   out_pos_reg, out_pos_next;
    logic [sdde_pkg::DIGIT_W-1:0] out_code_reg, out_code_next;
    logic                         out_last_reg, out_last_next;
    logic                         slot;
    logic                         emit;
    logic                         mag_last;

    // The output register frees up when it is empty or being transferred.
    assign slot     = !out_valid_reg || digit_ch.ready;
    assign emit     = active_reg && slot;
    assign mag_last = (rem_reg[sdde_pkg::BCD_W-1:sdde_pkg::DIGIT_W] == '0);

    always_comb
    begin
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        neg_next       = neg_reg;
        active_next    = active_reg;
        minus_next     = minus_reg;
        out_valid_next = out_valid_reg && !digit_ch.ready;
        out_pos_next   = out_pos_reg;
        out_code_next  = out_code_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            rem_next    = bcd;
            pos_next    = sdde_pkg::FIRST_POS;
            neg_next    = neg;
            active_next = 1'b1;
            minus_next  = 1'b0;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            out_pos_next   = pos_reg;
            pos_next       = pos_reg + sdde_pkg::POS_W'(1);
            if (minus_reg)
            begin
                out_code_next = sdde_pkg::MINUS_CODE;
                out_last_next = 1'b1;
                active_next   = 1'b0;
            end
            else
            begin
                // A zero magnitude still shows one digit, since the first digit is always sent.
                out_code_next = rem_reg[sdde_pkg::DIGIT_W-1:0];
                out_last_next = mag_last && !neg_reg;
                rem_next      = {{sdde_pkg::DIGIT_W{1'b0}},
                                 rem_reg[sdde_pkg::BCD_W-1:sdde_pkg::DIGIT_W]};
                if (mag_last)
                begin
                    if (neg_reg)
                        minus_next = 1'b1;
                    else
                        active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            minus_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            minus_reg     <= minus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        pos_reg      <= pos_next;
        neg_reg      <= neg_next;
        out_pos_reg  <= out_pos_next;
        out_code_reg <= out_code_next;
        out_last_reg <= out_last_next;
    end

    assign idle                    = !active_reg;
    assign digit_ch.valid          = out_valid_reg;
    assign digit_ch.digit_position = out_pos_reg;
    assign digit_ch.digit_code     = out_code_reg;
    assign digit_ch.last           = out_last_reg;

    `SDDE_ASSERT_NOW(a_load_when_idle, load, !active_reg,
                     "load while a value is still emitting")
    `SDDE_ASSERT_NOW(a_minus_is_last,
                     out_valid_reg && (out_code_reg == sdde_pkg::MINUS_CODE),
                     out_last_reg, "minus sign not flagged last")
    `SDDE_ASSERT_NOW(a_pos_range, out_valid_reg,
                     (out_pos_reg != '0) && (out_pos_reg <= 3'd6),
                     "digit position out of range")
    `SDDE_ASSERT_NEXT(a_last_ends, emit && out_last_next, !active_reg,
                      "emitter still active after final write")

endmodule

/* rtl/signed_decimal_digit_emitter.sv */
// Signed decimal digit emitter.
// value_ch takes one signed 16-bit value per transfer. digit_ch returns the
// display writes for it: the least significant digit at position 1, each
// higher digit at the next position, then the minus code at the next
// position for a negative value. The final write of a value has last set.
// Zero gives a single digit 0 at position 1.
// The magnitude is converted by a shift-and-add-three loop, one bit per
// cycle; the digits then leave one per cycle from a shift
// register of BCD digits through a single output register.
// The first write follows the end of the conversion, and the rest follow
// one per cycle while digit_ch is ready. A value gives 1 to 6 writes.
// value_ch is ready again once the final write sits in the output register,
// so the next value can enter while that write still waits.
// A stall on digit_ch holds the output register and pauses the emission.
// Reset empties the output register and returns the block to ready.
module signed_decimal_digit_emitter (
    input  logic          clk,
    input  logic          rst_n,
    sdde_value_if.sink    value_ch,
    sdde_digit_if.source  digit_ch
);

    sdde_pkg::conv_status_t conv_status;
    sdde_pkg::bcd_t         bcd;
    logic                   neg;
    logic                   emit_idle;
    logic                   start;

    assign value_ch.ready = emit_idle && !conv_status.busy && !conv_status.done;
    assign start          = value_ch.valid && value_ch.ready;

    sdde_dabble u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .value  (value_ch.value),
        .status (conv_status),
        .bcd    (bcd),
        .neg    (neg)
    );

    sdde_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (conv_status.done),
        .bcd      (bcd),
        .neg      (neg),
        .idle     (emit_idle),
        .digit_ch (digit_ch)
    );

endmodule
